>>> design/olist_pkg.sv
// olist_pkg: shared constants, action/status codes and the memory request word
// for the ordered list engine. No dependencies.
`default_nettype none

package olist_pkg;

    localparam int DEPTH = 256;
    localparam int AW    = 8;   // entry address bits
    localparam int DW    = 32;  // entry data bits
    localparam int LW    = 9;   // length, position and count bits

    localparam logic [2:0] ACT_APPEND  = 3'd0;
    localparam logic [2:0] ACT_PREPEND = 3'd1;
    localparam logic [2:0] ACT_INSERT  = 3'd2;
    localparam logic [2:0] ACT_REM_IDX = 3'd3;
    localparam logic [2:0] ACT_REM_VAL = 3'd4;
    localparam logic [2:0] ACT_FIND    = 3'd5;
    localparam logic [2:0] ACT_COUNT   = 3'd6;
    localparam logic [2:0] ACT_READ    = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

>>> design/olist_mem.sv
// olist_mem: entry store, one write port and one read port, registered read data.
// Depends on olist_pkg.
`default_nettype none

module olist_mem
    import olist_pkg::*;
(
    input  wire logic          clk,
    input  wire mem_req_t      req,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/ordered_list_engine_unit.sv
// ordered_list_engine_unit: top level, request sequencer around the entry store.
// Depends on olist_pkg and olist_mem.
//
// Usage:
//   A request word (action, position, item_value) is taken at a rising edge
//   with start high and busy low. Exactly one result word (status,
//   found_position, match_count, read_value, list_length) follows, shown for
//   one cycle with done high; the receiver cannot hold it off.
//   The sequencer walks the affected entries through the single read port
//   of the store, one entry per cycle, and writes each shifted entry back
//   in the cycle after its read. The entries walked number length -
//   position for append, prepend and insert, length - position - 1 for
//   remove at index, length for remove by value, find and count, and 1 for
//   read. Rejected requests (full list, bad index), scans of an empty list
//   and moves with nothing to shift go straight from idle to the finish
//   state without walking any entry.
//   busy drops in the cycle done is shown, so a new request may be taken
//   then; one request is in work at a time.
//   Reset clears the length to zero; entry contents are left as they are
//   and are never read before being written.
`default_nettype none

module ordered_list_engine_unit
    import olist_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        action,
    input  wire logic [LW-1:0]     position,
    input  wire logic [DW-1:0]     item_value,
    output logic                   done,
    output logic [1:0]             status,
    output logic signed [LW-1:0]   found_position,
    output logic [LW-1:0]          match_count,
    output logic [DW-1:0]          read_value,
    output logic [LW-1:0]          list_length
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    mem_req_t      req;
    logic [DW-1:0] rdata;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [DW-1:0] val_reg, val_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] data_reg, data_next;
    logic [1:0]    st_reg, st_next;
    logic          err_reg, err_next;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [LW-1:0] found_reg, found_next;
    logic [LW-1:0] count_reg, count_next;
    logic [DW-1:0] rd_out_reg, rd_out_next;

    logic [LW-1:0] eff_pos;
    logic [LW-1:0] idx_inc;
    logic          eq;
    logic          up_op;

    olist_mem u_mem (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign idx_inc = idx_reg + LW'(1);
    assign eq      = (rdata == val_reg);
    assign up_op   = (op_reg == ACT_APPEND) || (op_reg == ACT_PREPEND)
                     || (op_reg == ACT_INSERT);

    always_comb
    begin
        case (action)
            ACT_APPEND:  eff_pos = len_reg;
            ACT_PREPEND: eff_pos = '0;
            default:     eff_pos = position;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        cnt_next       = cnt_reg;
        data_next      = data_reg;
        st_next        = st_reg;
        err_next       = err_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        rd_out_next    = rd_out_reg;
        req            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = action;
                    pos_next   = eff_pos;
                    val_next   = item_value;
                    st_next    = ST_OK;
                    err_next   = 1'b0;
                    hit_next   = 1'b0;
                    cnt_next   = '0;
                    issue_next = 1'b0;
                    state_next = S_FIN;
                    case (action)
                        ACT_APPEND, ACT_PREPEND, ACT_INSERT:
                        begin
                            if (len_reg == LW'(DEPTH))
                            begin
                                err_next = 1'b1;
                                st_next  = ST_FULL;
                            end
                            else if (eff_pos > len_reg)
                            begin
                                err_next = 1'b1;
                                st_next  = ST_RANGE;
                            end
                            else if (eff_pos != len_reg)
                            begin
                                idx_next   = len_reg - LW'(1);
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        ACT_REM_IDX:
                        begin
                            if (position >= len_reg)
                            begin
                                err_next = 1'b1;
                                st_next  = ST_RANGE;
                            end
                            else
                            begin
                                hit_next     = 1'b1;
                                hit_idx_next = position[AW-1:0];
                                idx_next     = position + LW'(1);
                                if ((position + LW'(1)) < len_reg)
                                begin
                                    issue_next = 1'b1;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            if (position >= len_reg)
                            begin
                                err_next = 1'b1;
                                st_next  = ST_RANGE;
                            end
                            else
                            begin
                                idx_next   = position;
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            idx_next = '0;
                            if (len_reg != '0)
                            begin
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (issue_reg)
                begin
                    req.re         = 1'b1;
                    req.raddr      = idx_reg[AW-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                    if (up_op)
                    begin
                        issue_next = (idx_reg != pos_reg);
                        idx_next   = idx_reg - LW'(1);
                    end
                    else if (op_reg == ACT_READ)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        issue_next = (idx_inc < len_reg);
                        idx_next   = idx_inc;
                    end
                end

                if (pend_reg)
                begin
                    case (op_reg)
                        ACT_APPEND, ACT_PREPEND, ACT_INSERT:
                        begin
                            req.we    = 1'b1;
                            req.waddr = pend_addr_reg + AW'(1);
                            req.wdata = rdata;
                        end
                        ACT_REM_IDX, ACT_REM_VAL:
                        begin
                            if (hit_reg)
                            begin
                                req.we    = 1'b1;
                                req.waddr = pend_addr_reg - AW'(1);
                                req.wdata = rdata;
                            end
                            else if (eq)
                            begin
                                hit_next     = 1'b1;
                                hit_idx_next = pend_addr_reg;
                            end
                        end
                        ACT_FIND:
                        begin
                            if (eq && !hit_reg)
                            begin
                                hit_next     = 1'b1;
                                hit_idx_next = pend_addr_reg;
                            end
                        end
                        ACT_COUNT:
                        begin
                            if (eq)
                            begin
                                cnt_next = cnt_reg + LW'(1);
                            end
                        end
                        default:
                        begin
                            data_next = rdata;
                        end
                    endcase
                end

                if (!issue_reg && !pend_reg)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                done_next   = 1'b1;
                status_next = st_reg;
                found_next  = '0;
                count_next  = '0;
                rd_out_next = '0;
                state_next  = S_IDLE;
                if (!err_reg)
                begin
                    case (op_reg)
                        ACT_APPEND, ACT_PREPEND, ACT_INSERT:
                        begin
                            req.we    = 1'b1;
                            req.waddr = pos_reg[AW-1:0];
                            req.wdata = val_reg;
                            len_next  = len_reg + LW'(1);
                        end
                        ACT_REM_IDX:
                        begin
                            len_next = len_reg - LW'(1);
                        end
                        ACT_REM_VAL:
                        begin
                            if (hit_reg)
                            begin
                                len_next = len_reg - LW'(1);
                            end
                            else
                            begin
                                status_next = ST_MISSING;
                            end
                        end
                        ACT_FIND:
                        begin
                            if (hit_reg)
                            begin
                                found_next = {1'b0, hit_idx_reg};
                            end
                            else
                            begin
                                found_next  = '1;
                                status_next = ST_MISSING;
                            end
                        end
                        ACT_COUNT:
                        begin
                            count_next = cnt_reg;
                        end
                        default:
                        begin
                            rd_out_next = data_reg;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= ACT_APPEND;
            len_reg    <= '0;
            idx_reg    <= '0;
            issue_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            cnt_reg    <= '0;
            st_reg     <= ST_OK;
            err_reg    <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= '0;
            count_reg  <= '0;
            rd_out_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
            hit_reg    <= hit_next;
            cnt_reg    <= cnt_next;
            st_reg     <= st_next;
            err_reg    <= err_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            count_reg  <= count_next;
            rd_out_reg <= rd_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        hit_idx_reg   <= hit_idx_next;
        data_reg      <= data_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign match_count    = count_reg;
    assign read_value     = rd_out_reg;
    assign list_length    = len_reg;

endmodule

`default_nettype wire

>>> design/olist_chk.sv
// olist_chk: port-level checks for ordered_list_engine_unit, bound to the top.
// Depends on olist_pkg.
`default_nettype none

module olist_chk
    import olist_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire logic [1:0]        status,
    input wire logic [LW-1:0]     found_position,
    input wire logic [LW-1:0]     match_count,
    input wire logic [DW-1:0]     read_value,
    input wire logic [LW-1:0]     list_length
);

    // accepted word always occupies the unit
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> list_length == LW'(DEPTH)
            && match_count == '0 && found_position == '0)
        else $error("full status with wrong length or fields");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> read_value == '0)
        else $error("read data on failed request");

endmodule

bind ordered_list_engine_unit olist_chk u_olist_chk (.*);

`default_nettype wire

>>> dv/ordered_list_checker.sv
// ordered_list_checker: predicts every result word of the ordered list engine from the
// request words it sees accepted, and compares the result words field by field.
// Depends on olist_pkg.
module ordered_list_checker
    import olist_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [2:0]           action,
    input  logic [LW-1:0]        position,
    input  logic [DW-1:0]        item_value,
    input  logic                 done,
    input  logic [1:0]           status,
    input  logic signed [LW-1:0] found_position,
    input  logic [LW-1:0]        match_count,
    input  logic [DW-1:0]        read_value,
    input  logic [LW-1:0]        list_length,
    output int                   fail_count,
    output int                   pending,
    output int                   words_checked,
    output int                   cur_length
);

    typedef struct packed {
        logic [1:0]    st;
        logic [LW-1:0] fpos;
        logic [LW-1:0] cnt;
        logic [DW-1:0] rdata;
        logic [LW-1:0] len;
    } result_t;

    logic [DW-1:0] entry_store [0:DEPTH-1];
    int            list_len;
    result_t       expected_results [$];
    result_t       want;

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        words_checked = 0;
        cur_length    = 0;
        list_len      = 0;
    end

    function automatic int first_hit(input logic [DW-1:0] val);
        for (int i = 0; i < list_len; i++)
        begin
            if (entry_store[i] == val)
                return i;
        end
        return list_len;
    endfunction

    function automatic void close_gap(input int at);
        for (int i = at; i + 1 < list_len; i++)
            entry_store[i] = entry_store[i + 1];
        list_len--;
    endfunction

    function automatic result_t apply_request(input logic [2:0] act,
                                              input logic [LW-1:0] pos,
                                              input logic [DW-1:0] val);
        result_t r;
        int      at;
        r = '0;
        case (act)
            ACT_APPEND, ACT_PREPEND, ACT_INSERT:
            begin
                if (act == ACT_APPEND)
                    at = list_len;
                else if (act == ACT_PREPEND)
                    at = 0;
                else
                    at = int'(pos);
                if (list_len >= DEPTH)
                    r.st = ST_FULL;
                else if (at > list_len)
                    r.st = ST_RANGE;
                else
                begin
                    for (int i = list_len; i > at; i--)
                        entry_store[i] = entry_store[i - 1];
                    entry_store[at] = val;
                    list_len++;
                end
            end
            ACT_REM_IDX:
            begin
                if (int'(pos) >= list_len)
                    r.st = ST_RANGE;
                else
                    close_gap(int'(pos));
            end
            ACT_REM_VAL:
            begin
                at = first_hit(val);
                if (at >= list_len)
                    r.st = ST_MISSING;
                else
                    close_gap(at);
            end
            ACT_FIND:
            begin
                at = first_hit(val);
                if (at >= list_len)
                begin
                    r.st   = ST_MISSING;
                    r.fpos = '1;
                end
                else
                    r.fpos = at[LW-1:0];
            end
            ACT_COUNT:
            begin
                for (int i = 0; i < list_len; i++)
                begin
                    if (entry_store[i] == val)
                        r.cnt++;
                end
            end
            default:
            begin
                if (int'(pos) >= list_len)
                    r.st = ST_RANGE;
                else
                    r.rdata = entry_store[pos];
            end
        endcase
        r.len = list_len[LW-1:0];
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [DW-1:0] exp_v,
                               input logic [DW-1:0] got_v);
        if (exp_v !== got_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, fname, exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            expected_results.delete();
            pending    <= 0;
            cur_length <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word with none expected, status %0d length %0d",
                             $time, status, list_length);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", DW'(want.st), DW'(status));
                    check_field("found_position", DW'(want.fpos),
                                DW'($unsigned(found_position)));
                    check_field("match_count", DW'(want.cnt), DW'(match_count));
                    check_field("read_value", want.rdata, read_value);
                    check_field("list_length", DW'(want.len), DW'(list_length));
                    words_checked++;
                end
            end
            if (start && !busy)
                expected_results = {expected_results,
                                    apply_request(action, position, item_value)};
            pending    <= expected_results.size();
            cur_length <= list_len;
        end
    end

endmodule

>>> dv/ordered_list_engine_unit_tb.sv
// ordered_list_engine_unit_tb: drives request words into the ordered list engine, fills
// the list to full and drains it, and gives the verdict. Depends on olist_pkg,
// ordered_list_engine_unit and ordered_list_checker.
module ordered_list_engine_unit_tb;
    import olist_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_WORDS   = 850;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic [2:0]           action     = ACT_APPEND;
    logic [LW-1:0]        position   = '0;
    logic [DW-1:0]        item_value = '0;
    logic                 busy;
    logic                 done;
    logic [1:0]           status;
    logic signed [LW-1:0] found_position;
    logic [LW-1:0]        match_count;
    logic [DW-1:0]        read_value;
    logic [LW-1:0]        list_length;

    int fail_count;
    int pending;
    int words_checked;
    int cur_length;
    int words_sent = 0;
    int idle_run   = 0;
    bit gaps_on    = 1'b1;

    always #1 clk = ~clk;

    ordered_list_engine_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .position       (position),
        .item_value     (item_value),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .match_count    (match_count),
        .read_value     (read_value),
        .list_length    (list_length)
    );

    ordered_list_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .position       (position),
        .item_value     (item_value),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .match_count    (match_count),
        .read_value     (read_value),
        .list_length    (list_length),
        .fail_count     (fail_count),
        .pending        (pending),
        .words_checked  (words_checked),
        .cur_length     (cur_length)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_run <= 0;
        else
        begin
            idle_run <= idle_run + 1;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("FAIL ordered_list_engine_unit");
                $finish;
            end
        end
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly values from a small pool so that finds, counts and removals hit
    function automatic logic [DW-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return DW'($urandom_range(0, 7));
        if (r < 60)
            return '1;
        if (r < 65)
            return '0;
        return DW'($urandom());
    endfunction

    function automatic logic [LW-1:0] pick_position();
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (r < 70)
            p = $urandom_range(0, (cur_length > 0) ? cur_length - 1 : 0);
        else if (r < 85)
            p = cur_length + $urandom_range(0, 2);
        else
            p = $urandom_range(0, 511);
        return p[LW-1:0];
    endfunction

    // mode 0: any action, 1: mostly additions, 2: mostly removals
    function automatic logic [2:0] pick_action(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 1 && r < 85)
            return 3'($urandom_range(ACT_APPEND, ACT_INSERT));
        if (mode == 2 && r < 60)
            return ACT_REM_IDX;
        if (mode == 2 && r < 85)
            return ACT_REM_VAL;
        return 3'($urandom_range(ACT_APPEND, ACT_READ));
    endfunction

    task automatic send_word(input logic [2:0] a, input logic [LW-1:0] p,
                             input logic [DW-1:0] v);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        action     <= a;
        position   <= p;
        item_value <= v;
        do @(posedge clk); while (busy);
        words_sent++;
    endtask

    task automatic send_random(input int mode);
        send_word(pick_action(mode), pick_position(), pick_value());
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases
        send_word(ACT_READ,    9'd0,   32'd5);
        send_word(ACT_REM_IDX, 9'd0,   32'd5);
        send_word(ACT_REM_VAL, 9'd0,   32'd5);
        send_word(ACT_FIND,    9'd0,   32'd5);
        send_word(ACT_COUNT,   9'd0,   32'd5);
        send_word(ACT_INSERT,  9'd1,   32'd5);
        // build a short list and touch every action
        send_word(ACT_INSERT,  9'd0,   32'h0000_0000);
        send_word(ACT_APPEND,  9'd0,   32'hFFFF_FFFF);
        send_word(ACT_PREPEND, 9'd511, 32'd5);
        send_word(ACT_INSERT,  9'd3,   32'd5);
        send_word(ACT_INSERT,  9'd256, 32'd7);
        send_word(ACT_FIND,    9'd0,   32'd5);
        send_word(ACT_COUNT,   9'd0,   32'd5);
        send_word(ACT_FIND,    9'd0,   32'hFFFF_FFFF);
        send_word(ACT_READ,    9'd3,   32'd0);
        send_word(ACT_READ,    9'd4,   32'd0);
        send_word(ACT_READ,    9'd511, 32'd0);
        send_word(ACT_REM_VAL, 9'd0,   32'd5);
        send_word(ACT_REM_IDX, 9'd2,   32'd0);
        send_word(ACT_REM_IDX, 9'd256, 32'd0);
        send_word(ACT_READ,    9'd0,   32'd0);
        send_word(ACT_COUNT,   9'd0,   32'd0);
        wait_all_results();

        // fill to capacity
        while (cur_length < DEPTH)
        begin
            send_random(1);
            if (cur_length >= DEPTH - 3)
                wait_all_results();
        end
        wait_all_results();
        send_word(ACT_APPEND,  9'd0,   pick_value());
        send_word(ACT_PREPEND, 9'd0,   pick_value());
        send_word(ACT_INSERT,  9'd0,   pick_value());
        send_word(ACT_INSERT,  9'd300, pick_value());
        send_word(ACT_READ,    9'd255, 32'd0);
        send_word(ACT_COUNT,   9'd0,   pick_value());
        repeat (20) send_random(1);

        // drain to empty
        while (cur_length > 0)
        begin
            send_random(2);
            if (cur_length <= 3)
                wait_all_results();
        end
        repeat (15) send_random(0);

        // mixed traffic, half of it back to back
        while (words_sent < TARGET_WORDS)
        begin
            gaps_on = (words_sent % 100) < 50;
            send_random((cur_length < 20) ? 1 : 0);
        end

        wait_all_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d request words and checked %0d results; the list went from empty",
                 words_sent, words_checked);
        $display("to full (%0d entries) and back, covering every action and error status.",
                 DEPTH);
        if (fail_count == 0)
            $display("PASS ordered_list_engine_unit");
        else
            $display("FAIL ordered_list_engine_unit");
        $finish;
    end

endmodule

>>> sim.f
design/olist_pkg.sv
design/olist_mem.sv
design/ordered_list_engine_unit.sv
design/olist_chk.sv
dv/ordered_list_checker.sv
dv/ordered_list_engine_unit_tb.sv
